// ----- hw/rtl/bls_pkg.sv -----
// ----------------------------------------------------------------------------
// bls_pkg
// types and constants shared by the bounded lifo stack and its cells
// ----------------------------------------------------------------------------
`default_nettype none

package bls_pkg;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_CHANGE = 2'd3
  } bls_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BADINDEX  = 2'd3
  } bls_status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } bls_state_e;

  localparam int unsigned WordW = 32;
  localparam int unsigned PosW  = 6;
  localparam int unsigned CapW  = 7;
  localparam logic signed [WordW-1:0] NegOne = -32'sd1;
  localparam logic [CapW-1:0] CapReset = 7'd64;

  typedef struct packed {
    bls_op_e                 op;
    logic signed [WordW-1:0] value;
    logic [PosW-1:0]         position;
  } bls_in_t;

  typedef struct packed {
    logic signed [WordW-1:0] data;
    bls_status_e             status;
    logic [CapW-1:0]         count;
    logic                    empty_res;
    logic                    full_res;
  } bls_out_t;

  // broadcast control for every cell of the chain
  typedef struct packed {
    logic             push;
    logic             pop;
    logic             wr;
    logic             rd;
    logic [WordW-1:0] value;
  } bls_cell_ctrl_t;

  // read token travelling toward the top cell
  typedef struct packed {
    logic             valid;
    logic [WordW-1:0] word;
  } bls_tok_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bls_cell.sv -----
// ----------------------------------------------------------------------------
// bls_cell
// one stack cell: holds one word, shifts with its neighbors, passes read token
// ----------------------------------------------------------------------------
`default_nettype none

module bls_cell #(
  parameter int unsigned IDX  = 0,
  parameter int unsigned IdxW = 6
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  bls_pkg::bls_cell_ctrl_t     ctrl_i,
  input  wire  [IdxW-1:0]             target_i,
  input  wire  [bls_pkg::WordW-1:0]   up_word_i,
  input  wire  [bls_pkg::WordW-1:0]   dn_word_i,
  input  bls_pkg::bls_tok_t           dn_tok_i,
  output logic [bls_pkg::WordW-1:0]   word_o,
  output bls_pkg::bls_tok_t           tok_o
);
  import bls_pkg::*;

  logic [WordW-1:0] word_d, word_q;
  bls_tok_t         tok_d, tok_q;
  logic             hit;

  assign hit = (target_i == IdxW'(IDX));

  always_comb begin
    word_d = word_q;
    if (ctrl_i.push) begin
      word_d = up_word_i;
    end else if (ctrl_i.pop) begin
      word_d = dn_word_i;
    end else if (ctrl_i.wr && hit) begin
      word_d = ctrl_i.value;
    end
  end

  always_comb begin
    if (ctrl_i.rd && hit) begin
      tok_d.valid = 1'b1;
      tok_d.word  = word_q;
    end else begin
      tok_d = dn_tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign word_o = word_q;
  assign tok_o  = tok_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bounded_lifo_stack.sv -----
// ----------------------------------------------------------------------------
// bounded_lifo_stack
// bounded lifo stack of signed words with push, pop, peek and change
// ----------------------------------------------------------------------------
// The stack is a row of DEPTH cells with the top entry always in cell 0:
// a push shifts every cell one place down and loads the new word on top, a
// pop shifts every cell one place up. Push, pop, change and any request that
// fails (overflow, underflow, bad index) go straight into the output register
// and show their result there in the next cycle. A peek that hits a held entry
// launches a read token from the addressed cell, which moves one cell per
// cycle toward cell 0 and then loads the output register; no new item is taken
// during that walk. One item is in flight at a time; a new item is taken in
// the same cycle a waiting result is taken. Capacity is written through
// cfg_we_i / cfg_wdata_i; the user must write it only while the block is idle,
// which the block does not enforce. It resets to 64 and saturates at DEPTH.
// Lowering it below the count keeps the held entries. Entries hold no reset
// value; only entries below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_lifo_stack #(
  parameter int unsigned DEPTH = 64
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire  [bls_pkg::CapW-1:0]    cfg_wdata_i,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  bls_pkg::bls_in_t            in_data_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output bls_pkg::bls_out_t           out_data_o
);
  import bls_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  // common width for count, capacity and position compares
  localparam int unsigned CmpW = (CntW > CapW) ? CntW : CapW;

  // configuration
  logic [CapW-1:0] cap_q;
  logic [CmpW-1:0] eff_cap;

  // fill level and control
  logic [CntW-1:0] count_d, count_q;
  bls_state_e      state_d, state_q;

  // output register
  logic     out_valid_d, out_valid_q;
  bls_out_t out_d, out_q;

  // cell chain
  bls_cell_ctrl_t   cell_ctrl;
  logic [IdxW-1:0]  target;
  logic [WordW-1:0] cell_word [DEPTH];
  bls_tok_t         cell_tok  [DEPTH];

  logic            acc;
  logic [CmpW-1:0] cnt_w, pos_w, cnt_next_w;
  logic            pos_ok, is_full, is_empty, peek_launch;

  // capacity saturates at the built depth
  assign eff_cap = (CmpW'(cap_q) > CmpW'(DEPTH)) ? CmpW'(DEPTH) : CmpW'(cap_q);

  assign cnt_w    = CmpW'(count_q);
  assign pos_w    = CmpW'(in_data_i.position);
  assign pos_ok   = (pos_w < cnt_w);
  assign is_full  = (cnt_w >= eff_cap);
  assign is_empty = (count_q == '0);

  // cell index counted from the top
  assign target = IdxW'(cnt_w - CmpW'(1) - pos_w);

  // take an item only while idle and when the output register is free or
  // being emptied
  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign acc         = in_valid_i && in_ready_o;
  assign peek_launch = acc && (in_data_i.op == OP_PEEK) && pos_ok;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (peek_launch) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cell_tok[0].valid) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // cell control, only an accepted item drives the chain
  always_comb begin
    cell_ctrl       = '0;
    cell_ctrl.value = in_data_i.value;
    if (acc) begin
      unique case (in_data_i.op)
        OP_PUSH:   cell_ctrl.push = !is_full;
        OP_POP:    cell_ctrl.pop  = !is_empty;
        OP_PEEK:   cell_ctrl.rd   = pos_ok;
        OP_CHANGE: cell_ctrl.wr   = pos_ok;
        default:   cell_ctrl      = '0;
      endcase
    end
  end

  // fill level and result
  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (acc && !peek_launch) begin
      out_valid_d = 1'b1;
      out_d.data   = '0;
      out_d.status = ST_OK;
      case (in_data_i.op)
        OP_PUSH: begin
          if (is_full) begin
            out_d.status = ST_OVERFLOW;
          end else begin
            count_d = count_q + CntW'(1);
          end
        end
        OP_POP: begin
          if (is_empty) begin
            out_d.status = ST_UNDERFLOW;
            out_d.data   = NegOne;
          end else begin
            count_d    = count_q - CntW'(1);
            out_d.data = cell_word[0];
          end
        end
        OP_PEEK: begin
          // only a miss lands here
          out_d.status = ST_BADINDEX;
          out_d.data   = NegOne;
        end
        default: begin
          if (!pos_ok) begin
            out_d.status = ST_BADINDEX;
          end
        end
      endcase
    end else if (state_q == S_SCAN && cell_tok[0].valid) begin
      // read token reached the top cell
      out_valid_d  = 1'b1;
      out_d.data   = cell_tok[0].word;
      out_d.status = ST_OK;
    end
    cnt_next_w       = CmpW'(count_d);
    out_d.count      = CapW'(count_d);
    out_d.empty_res  = (count_d == '0);
    out_d.full_res   = (cnt_next_w >= eff_cap);
    if (!(acc || (state_q == S_SCAN && cell_tok[0].valid))) begin
      out_d = out_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapReset;
      count_q     <= '0;
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      count_q     <= count_d;
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // chain of cells, cell 0 is the top of the stack
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WordW-1:0] up_word, dn_word;
    bls_tok_t         dn_tok;

    if (i == 0) begin : g_top
      assign up_word = in_data_i.value;
    end else begin : g_mid_up
      assign up_word = cell_word[i-1];
    end

    if (i == DEPTH - 1) begin : g_bottom
      assign dn_word = '0;
      assign dn_tok  = '0;
    end else begin : g_mid_dn
      assign dn_word = cell_word[i+1];
      assign dn_tok  = cell_tok[i+1];
    end

    bls_cell #(
      .IDX  (i),
      .IdxW (IdxW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (cell_ctrl),
      .target_i  (target),
      .up_word_i (up_word),
      .dn_word_i (dn_word),
      .dn_tok_i  (dn_tok),
      .word_o    (cell_word[i]),
      .tok_o     (cell_tok[i])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
